// ===== rtl/core/prq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the process ready queue scheduler.
// No dependencies.
package prq_pkg;

  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [3:0] QUANTUM_RESET = 4'd2;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SJF   = 2'd1,
    POL_RR    = 2'd2,
    POL_AGING = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_LOAD      = 3'd1,
    OP_STEP      = 3'd2,
    OP_SHIFT     = 3'd3,
    OP_SORT_EVEN = 3'd4,
    OP_SORT_ODD  = 3'd5,
    OP_AGE       = 3'd6
  } cell_op_e;

  typedef struct packed {
    logic [9:0]  start;
    logic [9:0]  length;
    logic [10:0] next_line;
    logic [9:0]  score;
    logic [3:0]  owner;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic     by_score;
    entry_t   load;
  } cell_ctrl_t;

  typedef struct packed {
    logic       func;
    logic [9:0] start_line;
    logic [9:0] line_count;
    logic [3:0] proc_id;
  } in_item_t;

  typedef struct packed {
    logic       line_valid;
    logic [9:0] line_addr;
    logic [3:0] line_owner;
    logic       proc_finished;
    logic       queue_empty;
    logic       queue_full_error;
  } out_item_t;

endpackage

// ===== rtl/core/prq_cell.sv =====
`timescale 1ns / 1ps
// One queue slot: holds a process entry, swaps with its right neighbour
// during sort passes and shifts left on dequeue or rotate. Uses prq_pkg.
module prq_cell import prq_pkg::*; #(
  parameter int QUEUE_DEPTH = 4,
  parameter int CELL_IDX    = 0
) (
  input  logic                               clk_i,
  input  cell_ctrl_t                         ctrl_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_i,
  input  entry_t                             left_i,
  input  logic                               left_swap_i,
  input  entry_t                             right_i,
  input  entry_t                             head_i,
  output entry_t                             entry_o,
  output logic                               swap_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] MyIdx   = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] NextIdx = CNT_W'(CELL_IDX + 1);
  localparam bit IsOdd  = (CELL_IDX % 2) == 1;
  localparam bit IsHead = (CELL_IDX == 0);

  entry_t     ent_q, ent_d;
  logic [9:0] key_self, key_right;
  logic       pair_on;

  assign key_self  = ctrl_i.by_score ? ent_q.score   : ent_q.length;
  assign key_right = ctrl_i.by_score ? right_i.score : right_i.length;

  assign pair_on = ((ctrl_i.op == OP_SORT_EVEN) && !IsOdd) ||
                   ((ctrl_i.op == OP_SORT_ODD) && IsOdd);
  assign swap_o  = pair_on && (NextIdx < count_i) && (key_self > key_right);

  always_comb begin
    ent_d = ent_q;
    unique case (ctrl_i.op)
      OP_LOAD: begin
        if (count_i == MyIdx) ent_d = ctrl_i.load;
      end
      OP_STEP: begin
        if (IsHead) ent_d.next_line = ent_q.next_line + 11'd1;
      end
      OP_SHIFT: begin
        if (NextIdx < count_i) begin
          ent_d = right_i;
        end else if (NextIdx == count_i) begin
          ent_d = head_i;
        end
      end
      OP_SORT_EVEN, OP_SORT_ODD: begin
        if (swap_o) begin
          ent_d = right_i;
        end else if (left_swap_i) begin
          ent_d = left_i;
        end
      end
      OP_AGE: begin
        if (!IsHead && (MyIdx < count_i) && (ent_q.score != 10'd0)) begin
          ent_d.score = ent_q.score - 10'd1;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign entry_o = ent_q;

endmodule

// ===== rtl/core/process_ready_queue_scheduler_core.sv =====
`timescale 1ns / 1ps
// Ready queue scheduler: a row of prq_cell slots driven by a sequencer.
// Enqueue: straight to the result. Tick: under SJF or aging with a re-sort
// pending, SORT (one odd-even sort pass per cycle, QUEUE_DEPTH passes per
// sort); then STEP, then SHIFT, AGE and SORT as the policy needs. One item
// in flight, held in EMIT while the output register is stalled. Reset
// clears control state, sets policy FCFS and quantum 2; slots are not reset.
module process_ready_queue_scheduler_core import prq_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [3:0] cfg_wdata_i
);

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PASS_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  FullCnt  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PASS_W-1:0] LastPass = PASS_W'(QUEUE_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SORT  = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_AGE   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  policy_e           policy_q, policy_d;
  logic [3:0]        quantum_q, quantum_d;
  logic              pending_q, pending_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [3:0]        qused_q, qused_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic              post_q, post_d;
  logic              drop_q, drop_d;
  out_item_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  cell_ctrl_t        ctrl;
  entry_t            ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] swap;
  entry_t            head;
  logic [10:0]       line_inc, line_end;
  logic              done;
  logic [3:0]        qlimit, qused_inc;
  logic [9:0]        new_len;

  assign head      = ent[0];
  assign line_inc  = head.next_line + 11'd1;
  assign line_end  = {1'b0, head.start} + {1'b0, head.length};
  assign done      = line_inc >= line_end;
  assign qlimit    = (quantum_q == 4'd0) ? 4'd1 : quantum_q;
  assign qused_inc = qused_q + 4'd1;
  assign new_len   = (in_item_i.line_count == 10'd0) ? 10'd1 : in_item_i.line_count;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    policy_d    = policy_q;
    quantum_d   = quantum_q;
    pending_d   = pending_q;
    count_d     = count_q;
    qused_d     = qused_q;
    pass_d      = pass_q;
    post_d      = post_q;
    drop_d      = drop_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    ctrl.op             = OP_HOLD;
    ctrl.by_score       = (policy_q == POL_AGING);
    ctrl.load.start     = in_item_i.start_line;
    ctrl.load.length    = new_len;
    ctrl.load.next_line = {1'b0, in_item_i.start_line};
    ctrl.load.score     = new_len;
    ctrl.load.owner     = in_item_i.proc_id;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLICY: begin
          policy_d  = policy_e'(cfg_wdata_i[1:0]);
          pending_d = 1'b1;
        end
        CFG_QUANTUM: quantum_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          if (in_item_i.func == FUNC_ENQUEUE) begin
            if (count_q == FullCnt) begin
              res_d.queue_full_error = 1'b1;
            end else begin
              ctrl.op   = OP_LOAD;
              count_d   = count_q + CNT_W'(1);
              pending_d = 1'b1;
            end
            state_d = ST_EMIT;
          end else if (count_q == '0) begin
            state_d = ST_EMIT;
          end else begin
            pending_d = 1'b0;
            pass_d    = '0;
            post_d    = 1'b0;
            if (pending_q && (policy_q == POL_SJF || policy_q == POL_AGING)) begin
              state_d = ST_SORT;
            end else begin
              state_d = ST_STEP;
            end
          end
        end
      end
      ST_SORT: begin
        ctrl.op = pass_q[0] ? OP_SORT_ODD : OP_SORT_EVEN;
        pass_d  = pass_q + PASS_W'(1);
        if (pass_q == LastPass) begin
          state_d = post_q ? ST_EMIT : ST_STEP;
        end
      end
      ST_STEP: begin
        ctrl.op             = OP_STEP;
        res_d.line_valid    = 1'b1;
        res_d.line_addr     = head.next_line[9:0];
        res_d.line_owner    = head.owner;
        res_d.proc_finished = done;
        drop_d              = done;
        state_d             = ST_EMIT;
        case (policy_q)
          POL_RR: begin
            if (done || (qused_inc >= qlimit)) begin
              qused_d = 4'd0;
              state_d = ST_SHIFT;
            end else begin
              qused_d = qused_inc;
            end
          end
          POL_AGING: begin
            if (done) begin
              state_d = ST_SHIFT;
            end else if (head.score != 10'd0) begin
              state_d = ST_AGE;
            end
          end
          default: begin
            if (done) state_d = ST_SHIFT;
          end
        endcase
      end
      ST_SHIFT: begin
        ctrl.op = OP_SHIFT;
        if (drop_q) count_d = count_q - CNT_W'(1);
        state_d = (drop_q && policy_q == POL_AGING) ? ST_AGE : ST_EMIT;
      end
      ST_AGE: begin
        ctrl.op = OP_AGE;
        pass_d  = '0;
        post_d  = 1'b1;
        state_d = ST_SORT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_item_d             = res_q;
          out_item_d.queue_empty = (count_q == '0);
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POL_FCFS;
      quantum_q   <= QUANTUM_RESET;
      pending_q   <= 1'b0;
      count_q     <= '0;
      qused_q     <= 4'd0;
      pass_q      <= '0;
      post_q      <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      policy_q    <= policy_d;
      quantum_q   <= quantum_d;
      pending_q   <= pending_d;
      count_q     <= count_d;
      qused_q     <= qused_d;
      pass_q      <= pass_d;
      post_q      <= post_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_swap;

    if (g == 0) begin : g_first
      assign left_ent  = ent[0];
      assign left_swap = 1'b0;
    end else begin : g_mid
      assign left_ent  = ent[g-1];
      assign left_swap = swap[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = ent[g];
    end else begin : g_inner
      assign right_ent = ent[g+1];
    end

    prq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .left_i      (left_ent),
      .left_swap_i (left_swap),
      .right_i     (right_ent),
      .head_i      (head),
      .entry_o     (ent[g]),
      .swap_o      (swap[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/prq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the scheduler core and the bind that attaches them.
// Uses prq_pkg; binds to process_ready_queue_scheduler_core.
module prq_checker import prq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.line_valid |->
      out_item_o.line_addr == 10'd0 && out_item_o.line_owner == 4'd0 &&
      !out_item_o.proc_finished)
    else $error("line fields set without a line");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.queue_full_error |->
      !out_item_o.queue_empty && !out_item_o.line_valid)
    else $error("full refusal reported with empty queue or a line");

  a_line_leaves_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.line_valid && !out_item_o.proc_finished |->
      !out_item_o.queue_empty)
    else $error("unfinished process but queue reported empty");

endmodule

bind process_ready_queue_scheduler_core prq_checker u_prq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench of the process ready queue scheduler: directed and random items, with
// every result checked against a behavioural model of the ready queue.
// Depends on prq_pkg and process_ready_queue_scheduler_core.
module testbench;
  import prq_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 205;
  localparam int PRINT_LIMIT = 100;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic       cfg_idx = CFG_POLICY;
  logic [3:0] cfg_wdata = '0;

  entry_t      sched_slot [QUEUE_DEPTH];
  int unsigned sched_count;
  logic [3:0]  sched_quantum_used;
  bit          sched_resort;
  policy_e     sched_policy;
  logic [3:0]  sched_quantum;

  out_item_t   lines_due [$];
  out_item_t   line_want;
  int          mismatches = 0;
  int          burst_left = 0;
  int          ready_hold = 0;
  int          quiet_cycles = 0;

  process_ready_queue_scheduler_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- queue model

  function automatic void clear_model();
    sched_count        = 0;
    sched_quantum_used = '0;
    sched_resort       = 1'b0;
    sched_policy       = POL_FCFS;
    sched_quantum      = QUANTUM_RESET;
  endfunction

  function automatic logic [9:0] sort_key(input entry_t e, input bit by_score);
    return by_score ? e.score : e.length;
  endfunction

  // stable insertion sort, by length or by score
  function automatic void sort_slots(input bit by_score);
    entry_t held;
    int     j;
    for (int i = 1; i < sched_count; i++) begin
      held = sched_slot[i];
      j = i;
      while (j > 0 && sort_key(sched_slot[j-1], by_score) > sort_key(held, by_score)) begin
        sched_slot[j] = sched_slot[j-1];
        j--;
      end
      sched_slot[j] = held;
    end
  endfunction

  function automatic void drop_head();
    for (int i = 1; i < sched_count; i++) sched_slot[i-1] = sched_slot[i];
    if (sched_count > 0) sched_count--;
  endfunction

  function automatic void rotate_head();
    entry_t head;
    if (sched_count < 2) return;
    head = sched_slot[0];
    for (int i = 1; i < sched_count; i++) sched_slot[i-1] = sched_slot[i];
    sched_slot[sched_count-1] = head;
  endfunction

  function automatic void apply_reg(input logic idx, input logic [3:0] val);
    if (idx == CFG_POLICY) begin
      sched_policy = policy_e'(val[1:0]);
      sched_resort = 1'b1;
    end else begin
      sched_quantum = val;
    end
  endfunction

  function automatic out_item_t predict_line(input in_item_t it);
    out_item_t   res;
    entry_t      fresh;
    logic [10:0] stop;
    logic [3:0]  turn;
    bit          done;
    bit          zero_score;
    res = '0;
    if (it.func == FUNC_ENQUEUE) begin
      if (sched_count >= QUEUE_DEPTH) begin
        res.queue_full_error = 1'b1;
      end else begin
        fresh.start     = it.start_line;
        fresh.length    = (it.line_count == '0) ? 10'd1 : it.line_count;
        fresh.next_line = {1'b0, it.start_line};
        fresh.score     = fresh.length;
        fresh.owner     = it.proc_id;
        sched_slot[sched_count] = fresh;
        sched_count++;
        sched_resort = 1'b1;
      end
      res.queue_empty = (sched_count == 0);
      return res;
    end
    if (sched_count == 0) begin
      res.queue_empty = 1'b1;
      return res;
    end
    if (sched_resort) begin
      if (sched_policy == POL_SJF) sort_slots(1'b0);
      else if (sched_policy == POL_AGING) sort_slots(1'b1);
      sched_resort = 1'b0;
    end
    zero_score = (sched_slot[0].score == '0);
    stop = {1'b0, sched_slot[0].start} + {1'b0, sched_slot[0].length};
    res.line_valid = 1'b1;
    res.line_addr  = sched_slot[0].next_line[9:0];
    res.line_owner = sched_slot[0].owner;
    sched_slot[0].next_line = sched_slot[0].next_line + 11'd1;
    done = (sched_slot[0].next_line >= stop);
    res.proc_finished = done;
    case (sched_policy)
      POL_RR: begin
        turn = (sched_quantum == '0) ? 4'd1 : sched_quantum;
        sched_quantum_used = sched_quantum_used + 4'd1;
        if (done) begin
          drop_head();
          sched_quantum_used = '0;
        end else if (sched_quantum_used >= turn) begin
          rotate_head();
          sched_quantum_used = '0;
        end
      end
      POL_AGING: begin
        if (done) drop_head();
        if (done || !zero_score) begin
          for (int i = 1; i < sched_count; i++)
            if (sched_slot[i].score != '0) sched_slot[i].score = sched_slot[i].score - 10'd1;
          sort_slots(1'b1);
        end
      end
      default: if (done) drop_head();
    endcase
    res.queue_empty = (sched_count == 0);
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int sender_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    return ($urandom_range(0, 1) == 0) ? 0 : gap_length();
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    lines_due.push_back(predict_line(it));
  endtask

  task automatic enqueue(input logic [9:0] start, input logic [9:0] count,
                         input logic [3:0] id);
    send_item(in_item_t'{func: FUNC_ENQUEUE, start_line: start, line_count: count,
                         proc_id: id});
  endtask

  task automatic run_ticks(input int n);
    in_item_t it;
    repeat (n) begin
      it.func       = FUNC_TICK;
      it.start_line = 10'($urandom_range(0, 1023));
      it.line_count = 10'($urandom_range(0, 1023));
      it.proc_id    = 4'($urandom_range(0, 15));
      send_item(it);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (lines_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_policy(input policy_e p);
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    write_reg(CFG_POLICY, {junk, p});
  endtask

  task automatic set_quantum(input logic [3:0] q);
    write_reg(CFG_QUANTUM, q);
  endtask

  task automatic random_item();
    in_item_t it;
    int       tick_pct;
    int       pick;
    tick_pct = (sched_count == 0) ? 20 : (sched_count >= QUEUE_DEPTH) ? 80 : 55;
    it.func = ($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : FUNC_ENQUEUE;
    it.start_line = 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 5) it.line_count = '0;
    else if (pick < 75) it.line_count = 10'($urandom_range(1, 6));
    else it.line_count = 10'($urandom_range(7, 40));
    it.proc_id = 4'($urandom_range(0, 15));
    send_item(it);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_fcfs_limits();
    run_ticks(1);                     // empty queue
    enqueue(10'd1022, 10'd3, 4'd15);  // addresses wrap past 1023
    enqueue(10'd0, 10'd0, 4'd0);      // zero length runs one line
    enqueue(10'd5, 10'd2, 4'd3);
    enqueue(10'd512, 10'd1, 4'd8);
    enqueue(10'd100, 10'd1, 4'd1);    // refused, queue full
    run_ticks(4);
  endtask

  task automatic test_sjf_preempt();
    run_ticks(1);
    set_policy(POL_SJF);
    enqueue(10'd300, 10'd1, 4'd6);    // shorter jobs overtake the partly run head
    run_ticks(2);
  endtask

  task automatic test_round_robin_quantum();
    set_policy(POL_RR);
    set_quantum(4'd0);
    enqueue(10'd40, 10'd4, 4'd2);
    enqueue(10'd80, 10'd6, 4'd4);
    run_ticks(2);
    set_quantum(4'd3);
    run_ticks(2);
    set_quantum(4'd1);                // lowered mid-turn
    run_ticks(1);
  endtask

  task automatic test_aging_scores();
    set_policy(POL_AGING);
    enqueue(10'd900, 10'd2, 4'd12);
    run_ticks(6);
  endtask

  task automatic test_random_mix();
    policy_e    plan_policy [8];
    logic [3:0] plan_quantum [8];
    plan_policy  = '{POL_FCFS, POL_SJF, POL_RR, POL_AGING, POL_RR, POL_AGING, POL_SJF, POL_RR};
    plan_quantum = '{4'd2, 4'd7, 4'd1, 4'd15, 4'd0, 4'd3, 4'd15, 4'd5};
    for (int p = 0; p < 8; p++) begin
      set_quantum(plan_quantum[p]);
      set_policy(plan_policy[p]);
      repeat (PHASE_ITEMS) random_item();
    end
  endtask

  task automatic test_long_scripts();
    set_policy(POL_RR);
    set_quantum(4'd15);
    enqueue(10'd1023, 10'd1023, 4'd15);
    repeat (3) enqueue(10'($urandom_range(0, 1023)), 10'($urandom_range(512, 1023)),
                       4'($urandom_range(0, 15)));
    run_ticks(40);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string field, input logic [17:0] got,
                                 input logic [17:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] %s mismatch: got %0h, expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (lines_due.size() == 0) begin
        report_mismatch("unexpected item", out_item, '0);
      end else begin
        line_want = lines_due.pop_front();
        if (out_item.line_valid !== line_want.line_valid)
          report_mismatch("line_valid", 18'(out_item.line_valid),
                          18'(line_want.line_valid));
        if (out_item.line_addr !== line_want.line_addr)
          report_mismatch("line_addr", 18'(out_item.line_addr), 18'(line_want.line_addr));
        if (out_item.line_owner !== line_want.line_owner)
          report_mismatch("line_owner", 18'(out_item.line_owner),
                          18'(line_want.line_owner));
        if (out_item.proc_finished !== line_want.proc_finished)
          report_mismatch("proc_finished", 18'(out_item.proc_finished),
                          18'(line_want.proc_finished));
        if (out_item.queue_empty !== line_want.queue_empty)
          report_mismatch("queue_empty", 18'(out_item.queue_empty),
                          18'(line_want.queue_empty));
        if (out_item.queue_full_error !== line_want.queue_full_error)
          report_mismatch("queue_full_error", 18'(out_item.queue_full_error),
                          18'(line_want.queue_full_error));
      end
    end
  end

  // receiver back-pressure: short stalls, the odd long one, and long ready runs
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= gap_length();
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fcfs_limits();
    test_sjf_preempt();
    test_round_robin_quantum();
    test_aging_scores();
    test_random_mix();
    test_long_scripts();
    drain_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
